@@ rtl/core/pdv_pkg.sv @@
// ----------------------------------------------------------------------------
// pdv_pkg
// shared types and constants of the perspective divide / viewport block
// ----------------------------------------------------------------------------
`default_nettype none

package pdv_pkg;

  localparam int unsigned RegBits = 13;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  localparam logic [RegBits-1:0] WidthReset  = 13'd800;
  localparam logic [RegBits-1:0] HeightReset = 13'd600;

endpackage

`default_nettype wire

@@ rtl/core/pdv_div_stage.sv @@
// ----------------------------------------------------------------------------
// pdv_div_stage
// one registered radix-2 restoring divide step for three lanes
// ----------------------------------------------------------------------------
`default_nettype none

module pdv_div_stage #(
  parameter int unsigned NumBits = 80,
  parameter int unsigned DenBits = 48,
  parameter int unsigned SideBits = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [NumBits-1:0]  num_i [3],
  input  wire logic [DenBits:0]    rem_i [3],
  input  wire logic [DenBits-1:0]  den_i [3],
  input  wire logic [SideBits-1:0] side_i,
  output logic                     valid_o,
  output logic [NumBits-1:0]       num_o [3],
  output logic [DenBits:0]         rem_o [3],
  output logic [DenBits-1:0]       den_o [3],
  output logic [SideBits-1:0]      side_o
);

  logic [NumBits-1:0] num_d [3];
  logic [DenBits:0]   rem_d [3];
  logic [DenBits+1:0] shift;
  logic [DenBits+1:0] diff;

  // num holds dividend bits shifting out the top and quotient bits in at the bottom
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      shift    = {rem_i[l], num_i[l][NumBits-1]};
      diff     = shift - {2'b00, den_i[l]};
      if (!diff[DenBits+1]) begin
        rem_d[l] = diff[DenBits:0];
        num_d[l] = {num_i[l][NumBits-2:0], 1'b1};
      end else begin
        rem_d[l] = shift[DenBits:0];
        num_d[l] = {num_i[l][NumBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o  <= num_d;
      rem_o  <= rem_d;
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/perspective_divide_viewport.sv @@
// ----------------------------------------------------------------------------
// perspective_divide_viewport
// clip space vertex to screen space, with view volume outcode
// ----------------------------------------------------------------------------
// usage: an item (clip_x/y/z/w) enters on in_valid_i when in_stall_o is low;
// a result leaves on out_valid_o when out_stall_i is low. screen_width and
// screen_height are written through cfg_valid_i/cfg_ready_o (always ready),
// index 0 width, index 1 height; write them only while the block is idle.
// structure: a front stage forms the numerators (x+w)*W, (w-y)*H and z and
// the denominators 2w, 2w, w as magnitudes; then one registered restoring
// divide step per quotient bit (3 lanes side by side), then rounding and
// saturation into the output register.
// path: the front register, the divide chain and the output register, with
// QBits = COORD_BITS + 1 + 13 + FRAC_BITS quotient bits (62 at defaults);
// throughput one item per cycle while the output is not stalled, set by the fully pipelined divide chain.
// stall: all stages advance together; a stall on the output freezes every
// stage, so in_stall_o is high whenever the output holds an untaken result;
// bubbles travel with the pipe and are not squeezed out.
// reset: all valid bits clear, registers return to 800 x 600.
// ----------------------------------------------------------------------------
`default_nettype none

module perspective_divide_viewport
  import pdv_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [COORD_BITS-1:0] clip_x_i,
  input  wire logic [COORD_BITS-1:0] clip_y_i,
  input  wire logic [COORD_BITS-1:0] clip_z_i,
  input  wire logic [COORD_BITS-1:0] clip_w_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [COORD_BITS-1:0]      screen_x_o,
  output logic [COORD_BITS-1:0]      screen_y_o,
  output logic [COORD_BITS-1:0]      depth_o,
  output logic [5:0]                 outcode_o,
  output logic                       w_is_zero_o,
  output logic                       saturated_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [0:0]            cfg_index_i,
  input  wire logic [RegBits-1:0]    cfg_data_i
);

  // magnitude widths: (x+w) fits COORD_BITS+1 signed -> COORD_BITS+1 magnitude
  localparam int unsigned MagBits = COORD_BITS + 1 + RegBits;  // numerator magnitude
  localparam int unsigned DenBits = COORD_BITS + 1;            // |2w|
  localparam int unsigned QBits   = MagBits + FRAC_BITS;       // quotient bits
  localparam int unsigned NumBits = QBits;
  localparam int unsigned SideBits = 3 + 6 + 1;                // signs, outcode, wzero

  // ---------------- configuration registers
  logic [RegBits-1:0] width_q, height_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // global advance: pipe moves unless the output holds an untaken result
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------- front stage: outcode, products, magnitudes
  logic signed [COORD_BITS-1:0] xs, ys, zs, ws;
  logic signed [COORD_BITS+1:0] sum_x, sum_y;
  logic signed [MagBits+1:0]    prod_x, prod_y;
  logic [5:0]                   code;
  logic [NumBits-1:0]           f_num [3];
  logic [DenBits-1:0]           f_den [3];
  logic [SideBits-1:0]          f_side;
  logic                         f_valid_q;
  logic [NumBits-1:0]           f_num_q [3];
  logic [DenBits-1:0]           f_den_q [3];
  logic [SideBits-1:0]          f_side_q;
  logic [DenBits:0]             zero_rem [3];
  logic signed [COORD_BITS:0]   w2;

  always_comb begin
    xs = signed'(clip_x_i);
    ys = signed'(clip_y_i);
    zs = signed'(clip_z_i);
    ws = signed'(clip_w_i);
    code[0] = zs < 0;
    code[1] = zs > ws;
    code[2] = (COORD_BITS+1)'(xs) < -(COORD_BITS+1)'(ws);
    code[3] = xs > ws;
    code[4] = (COORD_BITS+1)'(ys) < -(COORD_BITS+1)'(ws);
    code[5] = ys > ws;
    sum_x  = (COORD_BITS+2)'(xs) + (COORD_BITS+2)'(ws);
    sum_y  = (COORD_BITS+2)'(ws) - (COORD_BITS+2)'(ys);
    prod_x = (MagBits+2)'(sum_x) * $signed({1'b0, width_q});
    prod_y = (MagBits+2)'(sum_y) * $signed({1'b0, height_q});
    w2     = {ws, 1'b0};
    // numerators shifted by FRAC_BITS via zero low bits
    f_num[0] = {MagBits'(prod_x[MagBits+1] ? -prod_x : prod_x), {FRAC_BITS{1'b0}}};
    f_num[1] = {MagBits'(prod_y[MagBits+1] ? -prod_y : prod_y), {FRAC_BITS{1'b0}}};
    f_num[2] = {MagBits'(zs[COORD_BITS-1] ? -(MagBits+1)'(zs) : (MagBits+1)'(zs)),
                {FRAC_BITS{1'b0}}};
    f_den[0] = DenBits'(w2[COORD_BITS] ? -w2 : w2);
    f_den[1] = f_den[0];
    f_den[2] = DenBits'(ws[COORD_BITS-1] ? -(COORD_BITS+1)'(ws) : (COORD_BITS+1)'(ws));
    f_side = {prod_x[MagBits+1] ^ ws[COORD_BITS-1],
              prod_y[MagBits+1] ^ ws[COORD_BITS-1],
              zs[COORD_BITS-1] ^ ws[COORD_BITS-1],
              code, (ws == '0)};
    for (int l = 0; l < 3; l++) zero_rem[l] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (adv) begin
      f_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_num_q  <= f_num;
      f_den_q  <= f_den;
      f_side_q <= f_side;
    end
  end

  // ---------------- divide chain, one quotient bit per stage
  logic                v_c    [QBits+1];
  logic [NumBits-1:0]  num_c  [QBits+1][3];
  logic [DenBits:0]    rem_c  [QBits+1][3];
  logic [DenBits-1:0]  den_c  [QBits+1][3];
  logic [SideBits-1:0] side_c [QBits+1];

  assign v_c[0]    = f_valid_q;
  assign num_c[0]  = f_num_q;
  assign rem_c[0]  = zero_rem;
  assign den_c[0]  = f_den_q;
  assign side_c[0] = f_side_q;

  for (genvar s = 0; s < QBits; s++) begin : g_div
    pdv_div_stage #(
      .NumBits (NumBits),
      .DenBits (DenBits),
      .SideBits(SideBits)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(v_c[s]),
      .num_i  (num_c[s]),
      .rem_i  (rem_c[s]),
      .den_i  (den_c[s]),
      .side_i (side_c[s]),
      .valid_o(v_c[s+1]),
      .num_o  (num_c[s+1]),
      .rem_o  (rem_c[s+1]),
      .den_o  (den_c[s+1]),
      .side_o (side_c[s+1])
    );
  end

  // ---------------- round, sign, saturate into the output register
  localparam logic [NumBits:0] PosLim = (NumBits+1)'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam logic [NumBits:0] NegLim = PosLim + 1'b1;

  logic [NumBits:0]     qr   [3];
  logic [COORD_BITS-1:0] res  [3];
  logic [2:0]           sat;
  logic                 neg;
  logic                 wz;
  logic [SideBits-1:0]  sd;

  always_comb begin
    sd = side_c[QBits];
    wz = sd[0];
    for (int l = 0; l < 3; l++) begin
      // round half away from zero: r >= d - r
      qr[l] = {1'b0, num_c[QBits][l]} +
              (NumBits+1)'((rem_c[QBits][l] << 1) >= {1'b0, den_c[QBits][l]});
      neg   = sd[SideBits-1-l] && (qr[l] != '0);
      if (neg && qr[l] > NegLim) begin
        res[l] = {1'b1, {(COORD_BITS-1){1'b0}}};
        sat[l] = 1'b1;
      end else if (!neg && qr[l] > PosLim) begin
        res[l] = {1'b0, {(COORD_BITS-1){1'b1}}};
        sat[l] = 1'b1;
      end else begin
        res[l] = neg ? -qr[l][COORD_BITS-1:0] : qr[l][COORD_BITS-1:0];
        sat[l] = 1'b0;
      end
      if (wz) begin
        res[l] = '0;
        sat[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= v_c[QBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      screen_x_o  <= res[0];
      screen_y_o  <= res[1];
      depth_o     <= res[2];
      outcode_o   <= sd[6:1];
      w_is_zero_o <= wz;
      saturated_o <= |sat;
    end
  end

  // ---------------- checks
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(screen_x_o))
    else $error("output changed under stall");
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output blocked");
  a_wz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && w_is_zero_o) |-> (screen_x_o == '0 && !saturated_o))
    else $error("zero w gave nonzero result");

endmodule

`default_nettype wire

@@ dv/pdv_checker.sv @@
// ----------------------------------------------------------------------------
// pdv_checker
// watches the vertex, result and register channels of the perspective divide
// block, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pdv_checker
  import pdv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [31:0]        clip_x_i,
  input  logic [31:0]        clip_y_i,
  input  logic [31:0]        clip_z_i,
  input  logic [31:0]        clip_w_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [31:0]        screen_x_i,
  input  logic [31:0]        screen_y_i,
  input  logic [31:0]        depth_i,
  input  logic [5:0]         outcode_i,
  input  logic               w_is_zero_i,
  input  logic               saturated_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [RegBits-1:0] cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] dep;
    logic [5:0]  code;
    logic        wz;
    logic        sat;
  } screen_vtx_t;

  screen_vtx_t vtx_q[$];
  logic [RegBits-1:0] view_w, view_h;

  // rounded num * 2^16 / den, clamped to 32 bits; bit 32 flags the clamp
  function automatic logic [32:0] fix_div(input longint num, input longint den);
    logic [127:0] n, d, q, r, lim;
    logic neg;
    n = 128'(num < 0 ? -num : num) << 16;
    d = 128'(den < 0 ? -den : den);
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    neg = ((num < 0) != (den < 0)) && (q != 0);
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) return {1'b1, neg ? 32'h8000_0000 : 32'h7fff_ffff};
    return {1'b0, neg ? 32'(-q) : q[31:0]};
  endfunction

  function automatic screen_vtx_t project(input logic [31:0] cx, cy, cz, cw);
    longint x, y, z, w;
    logic [32:0] a, b, c;
    screen_vtx_t v;
    x = longint'(signed'(cx));
    y = longint'(signed'(cy));
    z = longint'(signed'(cz));
    w = longint'(signed'(cw));
    v.code = {y > w, y < -w, x > w, x < -w, z > w, z < 0};
    if (w == 0) begin
      v.sx = '0; v.sy = '0; v.dep = '0; v.wz = 1'b1; v.sat = 1'b0;
    end else begin
      a = fix_div((x + w) * longint'(view_w), 2 * w);
      b = fix_div((w - y) * longint'(view_h), 2 * w);
      c = fix_div(z, w);
      v.sx = a[31:0]; v.sy = b[31:0]; v.dep = c[31:0];
      v.wz = 1'b0;
      v.sat = a[32] | b[32] | c[32];
    end
    return v;
  endfunction

  assign pending_o = vtx_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    screen_vtx_t exp_v, got;
    if (!rst_ni) begin
      view_w   <= WidthReset;
      view_h   <= HeightReset;
      errors_o <= 0;
      vtx_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i)
        vtx_q.push_back(project(clip_x_i, clip_y_i, clip_z_i, clip_w_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_WIDTH) view_w <= cfg_data_i;
        else view_h <= cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{screen_x_i, screen_y_i, depth_i, outcode_i, w_is_zero_i, saturated_i};
        if (vtx_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result item %p", got);
          errors_o <= errors_o + 1;
        end else begin
          exp_v = vtx_q.pop_front();
          if (got !== exp_v) begin
            if (errors_o < 10)
              $display("result differs: exp x=%h y=%h d=%h oc=%h wz=%b sat=%b",
                       exp_v.sx, exp_v.sy, exp_v.dep, exp_v.code, exp_v.wz, exp_v.sat,
                       "  got x=%h y=%h d=%h oc=%h wz=%b sat=%b",
                       got.sx, got.sy, got.dep, got.code, got.wz, got.sat);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stimulus for the perspective divide / viewport block: directed corner
// vertices, then bursts of random vertices under several viewport sizes,
// with random output stalls; checking lives in pdv_checker
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import pdv_pkg::*;

  localparam int CycleLimit = 300000;

  logic               clk, rst_n;
  logic               in_valid, in_stall;
  logic [31:0]        clip_x, clip_y, clip_z, clip_w;
  logic               out_valid, out_stall;
  logic [31:0]        screen_x, screen_y, depth;
  logic [5:0]         outcode;
  logic               w_is_zero, saturated;
  logic               cfg_valid, cfg_ready;
  reg_idx_e           cfg_index;
  logic [RegBits-1:0] cfg_data;
  int                 errors, pending, cycles;
  int                 stall_mode, stall_left;

  perspective_divide_viewport dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .clip_x_i(clip_x), .clip_y_i(clip_y), .clip_z_i(clip_z), .clip_w_i(clip_w),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .screen_x_o(screen_x), .screen_y_o(screen_y), .depth_o(depth),
    .outcode_o(outcode), .w_is_zero_o(w_is_zero), .saturated_o(saturated),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  pdv_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .clip_x_i(clip_x), .clip_y_i(clip_y), .clip_z_i(clip_z), .clip_w_i(clip_w),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .screen_x_i(screen_x), .screen_y_i(screen_y), .depth_i(depth),
    .outcode_i(outcode), .w_is_zero_i(w_is_zero), .saturated_i(saturated),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("perspective_divide_viewport: mismatch");
      $finish;
    end
  end

  // receiver stall: modes of no, light and heavy back pressure, each held a while
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 300);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // one vertex item, held until taken
  task automatic send_vtx(input logic [31:0] x, y, z, w);
    @(negedge clk);
    in_valid <= 1'b1;
    clip_x <= x; clip_y <= y; clip_z <= z; clip_w <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_sender(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // drain the pipe, then let a pipeline length pass before touching registers
  task automatic drain();
    idle_sender(0);
    while (pending != 0) @(negedge clk);
    repeat (90) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [RegBits-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random vertex: mostly inside or near the view volume, some raw bit noise
  task automatic send_random();
    logic [31:0] x, y, z, w;
    int wmag;
    case ($urandom_range(0, 9))
      0, 1: begin
        x = $urandom(); y = $urandom(); z = $urandom(); w = $urandom();
      end
      2: begin
        // tiny w drives the quotients into saturation
        x = $urandom(); y = $urandom(); z = $urandom();
        w = $urandom_range(0, 1) ? $urandom_range(0, 3) : -$urandom_range(0, 3);
      end
      default: begin
        wmag = $urandom_range(1, 32'h0010_0000);
        w = $urandom_range(0, 4) ? wmag : -wmag;
        x = $urandom_range(0, 2 * wmag) - wmag + $urandom_range(0, 1) * wmag / 4;
        y = $urandom_range(0, 2 * wmag) - wmag - $urandom_range(0, 1) * wmag / 4;
        z = $urandom_range(0, wmag + wmag / 4) - wmag / 8;
      end
    endcase
    send_vtx(x, y, z, w);
  endtask

  task automatic random_phase(input int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && n > 0) begin
        send_random();
        burst--; n--;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    clip_x = '0; clip_y = '0; clip_z = '0; clip_w = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    cycles = 0;
    stall_mode = 0;
    stall_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners at the reset viewport
    send_vtx(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000);  // corner of volume
    send_vtx(32'h0, 32'h0, 32'h0, 32'h0001_0000);                          // center
    send_vtx(32'h1234_5678, 32'h8765_4321, 32'hffff_0000, 32'h0);          // zero w
    send_vtx(32'h0, 32'h0, 32'h0, 32'h0);                                  // all zero
    send_vtx(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);  // huge over tiny w
    send_vtx(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);  // most negative w
    send_vtx(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vtx(32'h0002_0000, 32'hfffe_0000, 32'h0003_0000, 32'hffff_0000);  // negative w
    send_vtx(32'hfffe_0000, 32'h0002_0000, 32'hffff_0000, 32'h0001_0000);  // outside the left, top and near sides
    send_vtx(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0003);  // rounding of inexact quotients
    send_vtx(32'h0000_8000, 32'h0000_4000, 32'h0000_0001, 32'h0000_0002);
    send_vtx(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff);
    drain();

    write_reg(REG_WIDTH, 13'd1);
    write_reg(REG_HEIGHT, 13'd1);
    random_phase(150);
    drain();

    write_reg(REG_WIDTH, 13'd4096);
    write_reg(REG_HEIGHT, 13'd4096);
    send_vtx(32'h7fff_0000, 32'h8001_0000, 32'h0, 32'h0000_0100);
    random_phase(150);
    drain();

    // out of range sizes are used as written
    write_reg(REG_WIDTH, 13'd0);
    write_reg(REG_HEIGHT, 13'h1fff);
    random_phase(150);
    drain();

    write_reg(REG_WIDTH, 13'h1fff);
    write_reg(REG_HEIGHT, 13'd0);
    random_phase(100);
    drain();

    write_reg(REG_WIDTH, RegBits'($urandom_range(1, 4096)));
    write_reg(REG_HEIGHT, RegBits'($urandom_range(1, 4096)));
    random_phase(150);
    drain();

    write_reg(REG_WIDTH, 13'd800);
    write_reg(REG_HEIGHT, 13'd600);
    random_phase(200);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("perspective_divide_viewport: match");
    end else begin
      $display("perspective_divide_viewport: mismatch");
    end
    $finish;
  end

endmodule
